// File: hw/rtl/lpht_pkg.sv
package lpht_pkg;

   localparam int MAX_SLOTS = 16;
   localparam int SLOT_W = $clog2(MAX_SLOTS);
   localparam int CNT_W = $clog2(MAX_SLOTS + 1);
   localparam int KEY_W = 24;
   localparam int SUM_W = 10;
   localparam int BIT_W = $clog2(SUM_W);
   localparam logic [CNT_W-1:0] ACTIVE_RESET = CNT_W'(11);

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_SEARCH = 2'd1,
      KIND_REMOVE = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_DUPLICATE = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      MARK_EMPTY   = 2'd0,
      MARK_USED    = 2'd1,
      MARK_DELETED = 2'd2
   } mark_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOD,
      ST_PROBE
   } state_type;

   typedef struct packed {
      logic load;
      logic mod_step;
      logic probe_step;
   } cmd_type;

   typedef struct packed {
      logic mod_last;
      logic probe_done;
   } sts_type;

endpackage

// File: hw/rtl/lpht_if.sv
interface lpht_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [23:0] key;

   modport source (output valid, output kind, output key, input ready);
   modport sink (input valid, input kind, input key, output ready);
endinterface

interface lpht_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [3:0] slot;
   logic [4:0] live_count;

   modport source (output valid, output status, output slot, output live_count, input ready);
   modport sink (input valid, input status, input slot, input live_count, output ready);
endinterface

// File: hw/rtl/lpht_ctrl.sv
module lpht_ctrl
   import lpht_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  logic    rsp_ready,
   output logic    rsp_valid,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      commit;

   // The result register is free when empty or when its word leaves this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign commit = cmd.probe_step && sts.probe_done;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MOD;
         end
         ST_MOD: begin
            if (sts.mod_last) state_in = ST_PROBE;
         end
         ST_PROBE: begin
            if (commit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_MOD: cmd.mod_step = 1'b1;
         ST_PROBE: cmd.probe_step = out_free;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hw/rtl/lpht_dp.sv
module lpht_dp
   import lpht_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [CNT_W-1:0]  csr_write_data,
   input  logic [1:0]        req_kind,
   input  logic [KEY_W-1:0]  req_key,
   input  cmd_type           cmd,
   output sts_type           sts,
   output logic [1:0]        rsp_status,
   output logic [SLOT_W-1:0] rsp_slot,
   output logic [CNT_W-1:0]  rsp_live_count
);

   logic [CNT_W-1:0]  active_ff;
   logic [CNT_W-1:0]  n_slots;
   logic [1:0]        kind_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [SLOT_W-1:0] rem_ff;
   logic [BIT_W-1:0]  bit_ff;
   logic [SLOT_W-1:0] idx_ff;
   logic [SLOT_W-1:0] probe_ff;
   logic [CNT_W-1:0]  count_ff;
   mark_type          mark_ff [MAX_SLOTS];
   logic [KEY_W-1:0]  slot_key_ff [MAX_SLOTS];
   status_type        status_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [CNT_W-1:0]  live_ff;

   logic [CNT_W-1:0]  rem_shift;
   logic [SLOT_W-1:0] rem_in;
   logic [CNT_W-1:0]  idx_inc;
   logic [SLOT_W-1:0] idx_in;
   mark_type          cur_mark;
   logic              key_match;
   logic              last_probe;
   logic              done;
   status_type        status_in;
   logic              write_used;
   logic              write_deleted;
   logic [CNT_W-1:0]  count_in;

   // Out-of-range slot counts clamp to the valid range.
   always_comb begin
      n_slots = active_ff;
      if (active_ff == '0) n_slots = CNT_W'(1);
      else if (active_ff > CNT_W'(MAX_SLOTS)) n_slots = CNT_W'(MAX_SLOTS);
   end

   // One restoring remainder step per cycle, most significant sum bit first.
   always_comb begin
      rem_shift = {rem_ff, sum_ff[bit_ff]};
      if (rem_shift >= n_slots) rem_shift = rem_shift - n_slots;
      rem_in = rem_shift[SLOT_W-1:0];
   end

   assign sts.mod_last = (bit_ff == '0);

   assign cur_mark = mark_ff[idx_ff];
   assign key_match = (slot_key_ff[idx_ff] == key_ff);
   assign last_probe = ({1'b0, probe_ff} == n_slots - CNT_W'(1));
   assign idx_inc = {1'b0, idx_ff} + CNT_W'(1);
   assign idx_in = (idx_inc == n_slots) ? '0 : idx_inc[SLOT_W-1:0];

   always_comb begin
      done = 1'b0;
      status_in = STATUS_NOT_FOUND;
      write_used = 1'b0;
      write_deleted = 1'b0;
      case (kind_ff)
         KIND_INSERT: begin
            if (cur_mark != MARK_USED) begin
               done = 1'b1;
               status_in = STATUS_OK;
               write_used = 1'b1;
            end else if (key_match) begin
               done = 1'b1;
               status_in = STATUS_DUPLICATE;
            end else if (last_probe) begin
               done = 1'b1;
               status_in = STATUS_FULL;
            end
         end
         KIND_SEARCH, KIND_REMOVE: begin
            if (cur_mark == MARK_EMPTY) begin
               done = 1'b1;
            end else if (cur_mark == MARK_USED && key_match) begin
               done = 1'b1;
               status_in = STATUS_OK;
               write_deleted = (kind_ff == KIND_REMOVE);
            end else if (last_probe) begin
               done = 1'b1;
            end
         end
         default: done = 1'b1;
      endcase
   end

   assign sts.probe_done = done;

   always_comb begin
      count_in = count_ff;
      if (write_used) count_in = count_ff + CNT_W'(1);
      else if (write_deleted && count_ff != '0) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
         count_ff <= '0;
         for (int i = 0; i < MAX_SLOTS; i++) mark_ff[i] <= MARK_EMPTY;
      end else begin
         if (csr_write_enable) active_ff <= csr_write_data;
         if (cmd.probe_step && done) begin
            count_ff <= count_in;
            if (write_used) mark_ff[idx_ff] <= MARK_USED;
            else if (write_deleted) mark_ff[idx_ff] <= MARK_DELETED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         key_ff <= req_key;
         sum_ff <= SUM_W'(req_key[23:16]) + SUM_W'(req_key[15:8]) + SUM_W'(req_key[7:0]);
         rem_ff <= '0;
         bit_ff <= BIT_W'(SUM_W - 1);
         probe_ff <= '0;
      end
      if (cmd.mod_step) begin
         rem_ff <= rem_in;
         bit_ff <= bit_ff - BIT_W'(1);
         if (sts.mod_last) idx_ff <= rem_in;
      end
      if (cmd.probe_step) begin
         if (done) begin
            status_ff <= status_in;
            slot_ff <= (status_in == STATUS_OK) ? idx_ff : '0;
            live_ff <= count_in;
            if (write_used) slot_key_ff[idx_ff] <= key_ff;
         end else begin
            idx_ff <= idx_in;
            probe_ff <= probe_ff + SLOT_W'(1);
         end
      end
   end

   assign rsp_status = status_ff;
   assign rsp_slot = slot_ff;
   assign rsp_live_count = live_ff;

endmodule

// File: hw/rtl/linear_probe_hash_table.sv
// Channel   Dir  Handshake     Word
// req_ch    in   valid/ready   kind[1:0], key[23:0]
// rsp_ch    out  valid/ready   status[1:0], slot[3:0], live_count[4:0]
// csr       in   write enable  active_slots[4:0]
//
// Each word is loaded, then reduced to its home slot by ten remainder steps, then probed
// one slot per cycle through the single mark and key read port while the output register
// is free, over p slots (1 to 16). The next word is accepted only after this one commits.
// Reset clears all slot marks, the live count and the handshake state.
// A finished result waits in the output register while the next word is taken; the probe
// walk stalls at whatever slot it has reached while that register is full and not taken.
module linear_probe_hash_table
   import lpht_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [4:0] csr_write_data,
   lpht_req_if.sink   req_ch,
   lpht_rsp_if.source rsp_ch
);

   cmd_type cmd;
   sts_type sts;

   lpht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   lpht_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_kind         (req_ch.kind),
      .req_key          (req_ch.key),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_status       (rsp_ch.status),
      .rsp_slot         (rsp_ch.slot),
      .rsp_live_count   (rsp_ch.live_count)
   );

endmodule
